// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked on a rising edge and
// disabled while the active-low reset is asserted
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- hw/rtl/utf16nl_pkg.sv -----
// ----------------------------------------------------------------------------
// utf16nl_pkg
// types, constants and helpers shared by the utf-16 newline converter
// ----------------------------------------------------------------------------
package utf16nl_pkg;

  // newline style codes, code three means no rewriting
  localparam logic [1:0] NL_UNIX = 2'd0;
  localparam logic [1:0] NL_MAC  = 2'd1;
  localparam logic [1:0] NL_WIN  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_SRC_NEWLINE = 2'd0;
  localparam logic [1:0] REG_DST_NEWLINE = 2'd1;
  localparam logic [1:0] REG_SWAP_BYTES  = 2'd2;

  localparam logic [7:0]  BOM_FIRST  = 8'hFE;
  localparam logic [7:0]  BOM_SECOND = 8'hFF;
  localparam logic [15:0] CODE_CR    = 16'h000D;
  localparam logic [15:0] CODE_LF    = 16'h000A;

  typedef struct packed {
    logic [7:0] first;
    logic [7:0] second;
  } unit_t;

  typedef struct packed {
    logic [7:0] first_byte;
    logic [7:0] second_byte;
    logic       end_of_stream;
  } in_item_t;

  typedef struct packed {
    unit_t u;
    logic  last;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    r0;
    result_t    r1;
  } result_pair_t;

  typedef struct packed {
    logic mark_seen;
    logic big_endian;
    logic pending_cr;
  } conv_state_t;

  typedef struct packed {
    logic [1:0] src_newline;
    logic [1:0] dst_newline;
    logic       swap_bytes;
  } cfg_t;

  // stream-order bytes, exchanged when swapping
  function automatic unit_t emit_bytes(logic [7:0] b0, logic [7:0] b1, logic swap);
    unit_t u;
    u.first  = swap ? b1 : b0;
    u.second = swap ? b0 : b1;
    return u;
  endfunction

  // a code point laid out in the stream's byte order
  function automatic unit_t emit_code(logic [15:0] code, logic big_endian, logic swap);
    unit_t u;
    if (big_endian) begin
      u = emit_bytes(code[15:8], code[7:0], swap);
    end else begin
      u = emit_bytes(code[7:0], code[15:8], swap);
    end
    return u;
  endfunction

endpackage

// ----- hw/rtl/utf16nl_in_reg.sv -----
// ----------------------------------------------------------------------------
// utf16nl_in_reg
// input register, takes a new unit whenever the held one moves on
// ----------------------------------------------------------------------------
module utf16nl_in_reg (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_valid_i,
  output logic                  s_ready_o,
  input  utf16nl_pkg::in_item_t s_item_i,
  input  logic                  move_i,
  output logic                  valid_o,
  output utf16nl_pkg::in_item_t item_o
);
  import utf16nl_pkg::*;

  logic     valid_q, valid_d;
  in_item_t item_q;
  logic     take;

  assign s_ready_o = !valid_q || move_i;
  assign take      = s_valid_i && s_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (move_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= s_item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ----- hw/rtl/utf16nl_decode.sv -----
// ----------------------------------------------------------------------------
// utf16nl_decode
// newline rewrite for one unit: up to two results and the next state
// ----------------------------------------------------------------------------
module utf16nl_decode (
  input  utf16nl_pkg::in_item_t     item_i,
  input  utf16nl_pkg::conv_state_t  state_i,
  input  utf16nl_pkg::cfg_t         cfg_i,
  output utf16nl_pkg::result_pair_t res_o,
  output utf16nl_pkg::conv_state_t  state_o
);
  import utf16nl_pkg::*;

  logic [15:0] code;
  logic        is_cr, is_lf, conv, pend, eos;
  logic [1:0]  n;
  unit_t       u0, u1, raw;

  assign eos   = item_i.end_of_stream;
  assign code  = state_i.big_endian ? {item_i.first_byte, item_i.second_byte}
                                    : {item_i.second_byte, item_i.first_byte};
  assign is_cr = (code == CODE_CR);
  assign is_lf = (code == CODE_LF);
  assign conv  = (cfg_i.src_newline != cfg_i.dst_newline) &&
                 (cfg_i.src_newline != 2'd3) && (cfg_i.dst_newline != 2'd3);
  assign raw   = emit_bytes(item_i.first_byte, item_i.second_byte, cfg_i.swap_bytes);

  always_comb begin
    unit_t cr_u, lf_u;
    cr_u = emit_code(CODE_CR, state_i.big_endian, cfg_i.swap_bytes);
    lf_u = emit_code(CODE_LF, state_i.big_endian, cfg_i.swap_bytes);
    n    = 2'd1;
    u0   = raw;
    u1   = raw;
    pend = 1'b0;
    if (!state_i.mark_seen) begin
      n = 2'd1;
    end else if (state_i.pending_cr) begin
      if (is_lf) begin
        if (cfg_i.dst_newline == NL_UNIX) begin
          u0 = lf_u;
        end else if (cfg_i.dst_newline == NL_MAC) begin
          u0 = cr_u;
        end else begin
          n  = 2'd2;
          u0 = cr_u;
          u1 = lf_u;
        end
      end else begin
        u0 = cr_u;
        if (is_cr && !eos) begin
          pend = 1'b1;
        end else begin
          n = 2'd2;
        end
      end
    end else if (conv && cfg_i.src_newline == NL_MAC && is_cr) begin
      if (cfg_i.dst_newline == NL_UNIX) begin
        u0 = lf_u;
      end else begin
        n  = 2'd2;
        u0 = cr_u;
        u1 = lf_u;
      end
    end else if (conv && cfg_i.src_newline == NL_UNIX && is_lf) begin
      u0 = cr_u;
      if (cfg_i.dst_newline == NL_WIN) begin
        n  = 2'd2;
        u1 = lf_u;
      end
    end else if (conv && cfg_i.src_newline == NL_WIN && is_cr) begin
      // windows cr waits for the next unit unless the stream ends here
      u0 = cr_u;
      if (eos) begin
        n = 2'd1;
      end else begin
        n    = 2'd0;
        pend = 1'b1;
      end
    end
  end

  always_comb begin
    res_o.count   = n;
    res_o.r0.u    = u0;
    res_o.r0.last = (n == 2'd1);
    res_o.r1.u    = u1;
    res_o.r1.last = 1'b1;
  end

  always_comb begin
    state_o.mark_seen  = !eos;
    state_o.big_endian = state_i.mark_seen ? state_i.big_endian
                         : (item_i.first_byte == BOM_FIRST &&
                            item_i.second_byte == BOM_SECOND);
    state_o.pending_cr = pend && !eos;
  end

endmodule

// ----- hw/rtl/utf16nl_out_buf.sv -----
// ----------------------------------------------------------------------------
// utf16nl_out_buf
// two-entry result buffer that drains one result per transfer
// ----------------------------------------------------------------------------
module utf16nl_out_buf (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      load_i,
  input  utf16nl_pkg::result_pair_t res_i,
  output logic                      free_o,
  output logic                      m_valid_o,
  input  logic                      m_ready_i,
  output utf16nl_pkg::result_t      m_res_o
);
  import utf16nl_pkg::*;

  logic [1:0] count_q, count_d;
  result_t    slot0_q, slot0_d, slot1_q, slot1_d;
  logic       pop;

  assign pop    = (count_q != 2'd0) && m_ready_i;
  // empty after this cycle's transfer
  assign free_o = (count_q == 2'd0) || (count_q == 2'd1 && m_ready_i);

  always_comb begin
    count_d = count_q;
    slot0_d = slot0_q;
    slot1_d = slot1_q;
    if (load_i) begin
      count_d = res_i.count;
      slot0_d = res_i.r0;
      slot1_d = res_i.r1;
    end else if (pop) begin
      count_d = count_q - 2'd1;
      slot0_d = slot1_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot0_q <= slot0_d;
    slot1_q <= slot1_d;
  end

  assign m_valid_o = (count_q != 2'd0);
  assign m_res_o   = slot0_q;

endmodule

// ----- hw/rtl/utf16_newline_converter.sv -----
// ----------------------------------------------------------------------------
// utf16_newline_converter
// utf-16 stream pass-through with byte order detection and newline rewrite
// ----------------------------------------------------------------------------
// usage: s_axis carries one code unit per transfer, tlast marks the end of a
//   stream; the first unit of each stream is the byte order mark (fe ff
//   selects big endian, anything else little endian) and is passed on.
//   m_axis returns zero, one or two units per input unit; tlast is set on
//   the final result caused by an input unit.
//   the cfg channel writes src_newline, dst_newline and swap_bytes by
//   index; it is always ready and should be used only while idle.
// flow: an accepted unit is held in the input register, then the rewrite
//   logic loads its results into a two-entry output buffer that feeds m_axis.
//   one unit per cycle while each makes at most one result and m_axis_tready
//   stays high; a unit that makes two holds back the next, since the single
//   output port drains the buffer one result per cycle. a windows cr is held
//   and makes no result until the next unit decides.
// reset: clears all valid flags, the byte order and held-cr state, and the
//   registers to style unix / no swap.
// stall: while m_axis_tready is low the buffer holds, the input register
//   fills, and s_axis_tready drops; nothing is lost.
// ----------------------------------------------------------------------------
module utf16_newline_converter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // first_byte [7:0], second_byte [15:8]
  input  logic        s_axis_tlast,  // end_of_stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // out_first_byte [7:0], out_second_byte [15:8]
  output logic        m_axis_tlast,  // last_of_run
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [1:0]  cfg_data_i
);
  import utf16nl_pkg::*;

  in_item_t     s_item, held_item;
  logic         held_valid, move, buf_free;
  conv_state_t  state_q, state_d;
  cfg_t         cfg_q, cfg_d;
  result_pair_t res;
  result_t      m_res;

  assign s_item.first_byte    = s_axis_tdata[7:0];
  assign s_item.second_byte   = s_axis_tdata[15:8];
  assign s_item.end_of_stream = s_axis_tlast;

  utf16nl_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .s_item_i  (s_item),
    .move_i    (move),
    .valid_o   (held_valid),
    .item_o    (held_item)
  );

  // a unit moves on once the buffer is drained, whatever it produces
  assign move = held_valid && buf_free;

  utf16nl_decode u_decode (
    .item_i  (held_item),
    .state_i (state_q),
    .cfg_i   (cfg_q),
    .res_o   (res),
    .state_o (state_d)
  );

  utf16nl_out_buf u_out_buf (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (move),
    .res_i     (res),
    .free_o    (buf_free),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_res_o   (m_res)
  );

  assign m_axis_tdata = {m_res.u.second, m_res.u.first};
  assign m_axis_tlast = m_res.last;

  // configuration registers, unknown indexes are dropped
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_SRC_NEWLINE: cfg_d.src_newline = cfg_data_i;
        REG_DST_NEWLINE: cfg_d.dst_newline = cfg_data_i;
        REG_SWAP_BYTES:  cfg_d.swap_bytes  = cfg_data_i[0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q   <= '0;
      state_q <= '0;
    end else begin
      cfg_q <= cfg_d;
      if (move) begin
        state_q <= state_d;
      end
    end
  end

endmodule

// ----- hw/rtl/utf16nl_checker.sv -----
// ----------------------------------------------------------------------------
// utf16nl_checker
// port-level checks for the utf-16 newline converter, bound to the top
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module utf16nl_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tlast,
  input logic        cfg_ready_o
);

  logic out_stall;

  assign out_stall = m_axis_tvalid && !m_axis_tready;

  // a stalled result holds
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, m_axis_tvalid && $stable({m_axis_tlast, m_axis_tdata}))

  // a result that is not last has its partner right behind it
  `ASSERT_NEXT(a_pair_follows, clk_i, rst_ni, m_axis_tvalid && !m_axis_tlast, m_axis_tvalid)

  // with no result waiting the input side never stalls
  `ASSERT_SAME(a_ready_when_empty, clk_i, rst_ni, !m_axis_tvalid, s_axis_tready)

  // register writes are always taken
  `ASSERT_SAME(a_cfg_ready, clk_i, rst_ni, 1'b1, cfg_ready_o)

endmodule

bind utf16_newline_converter utf16nl_checker u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .cfg_ready_o   (cfg_ready_o)
);

// ----- sim/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the utf-16 newline converter: a directed table of
// byte order marks, newline rewrites, held carriage returns and stream ends,
// then random streams under random styles, with both stream sides stalling
// at random, each result checked against typed units or a conversion model
// ----------------------------------------------------------------------------
module tb_top;
  import utf16nl_pkg::*;

  localparam int RANDOM_UNITS = 950;
  localparam int DRAIN_CYCLES = 8;       // input register plus output buffer, with margin
  localparam int CYCLE_LIMIT  = 400000;  // far above the slowest correct run
  localparam int GAP_PERCENT  = 38;

  typedef enum logic {ROW_UNIT, ROW_CFG} row_kind_e;

  // one line of the directed table; n_typed of zero leaves the row to the model
  typedef struct packed {
    row_kind_e  kind;
    cfg_t       styles;
    in_item_t   item;
    logic [1:0] n_typed;
    unit_t      t0;
    unit_t      t1;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [1:0]  cfg_data_i = '0;

  // conversion model state and register copy
  logic        pm_mark_seen = 1'b0;
  logic        pm_big_endian = 1'b0;
  logic        pm_held_cr = 1'b0;
  cfg_t        cfg_shadow = '0;

  unit_t       unit_results[$];     // units made by the latest input unit
  result_t     pending_results[$];  // expected output transfers, oldest first
  dir_row_t    dir_rows[$];

  logic        sender_gaps = 1'b1;
  logic        sink_gaps = 1'b1;
  int          cycle_count = 0;
  int          err_count = 0;
  int          units_sent = 0;
  int          streams_sent = 0;
  int          results_checked = 0;
  int          reg_writes = 0;

  always #1 clk = ~clk;

  utf16_newline_converter uut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    err_count++;
  endtask

  // ---------------------------------------------------------------------------
  // conversion model
  // ---------------------------------------------------------------------------

  // stream-order bytes, exchanged when the swap register is set
  function automatic void add_bytes(input logic [7:0] b0, input logic [7:0] b1);
    unit_t u;
    u.first  = cfg_shadow.swap_bytes ? b1 : b0;
    u.second = cfg_shadow.swap_bytes ? b0 : b1;
    unit_results.push_back(u);
  endfunction

  // a code point laid out in the byte order found in the mark
  function automatic void add_code(input logic [15:0] code);
    if (pm_big_endian) begin
      add_bytes(code[15:8], code[7:0]);
    end else begin
      add_bytes(code[7:0], code[15:8]);
    end
  endfunction

  function automatic void convert_unit(input in_item_t it);
    logic [15:0] code;
    logic        rewrite;
    logic [1:0]  src;
    logic [1:0]  dst;
    src = cfg_shadow.src_newline;
    dst = cfg_shadow.dst_newline;
    unit_results.delete();
    if (!pm_mark_seen) begin
      // byte order mark: only fe ff means big endian
      pm_big_endian = (it.first_byte == BOM_FIRST) && (it.second_byte == BOM_SECOND);
      pm_mark_seen  = 1'b1;
      add_bytes(it.first_byte, it.second_byte);
    end else begin
      code = pm_big_endian ? {it.first_byte, it.second_byte}
                           : {it.second_byte, it.first_byte};
      // style code three on either side turns rewriting off
      rewrite = (src != dst) && (src <= NL_WIN) && (dst <= NL_WIN);
      if (pm_held_cr) begin
        // the held cr is settled by this unit whatever the registers hold now
        pm_held_cr = 1'b0;
        if (code == CODE_LF) begin
          if (dst == NL_UNIX) begin
            add_code(CODE_LF);
          end else if (dst == NL_MAC) begin
            add_code(CODE_CR);
          end else begin
            add_code(CODE_CR);
            add_code(CODE_LF);
          end
        end else begin
          add_code(CODE_CR);
          if (code == CODE_CR && !it.end_of_stream) begin
            pm_held_cr = 1'b1;
          end else begin
            add_code(code);
          end
        end
      end else if (rewrite && src == NL_MAC && code == CODE_CR) begin
        if (dst == NL_UNIX) begin
          add_code(CODE_LF);
        end else begin
          add_code(CODE_CR);
          add_code(CODE_LF);
        end
      end else if (rewrite && src == NL_UNIX && code == CODE_LF) begin
        add_code(CODE_CR);
        if (dst == NL_WIN) begin
          add_code(CODE_LF);
        end
      end else if (rewrite && src == NL_WIN && code == CODE_CR) begin
        // a cr that ends the stream goes out at once
        if (it.end_of_stream) begin
          add_code(CODE_CR);
        end else begin
          pm_held_cr = 1'b1;
        end
      end else begin
        add_bytes(it.first_byte, it.second_byte);
      end
    end
    if (it.end_of_stream) begin
      pm_mark_seen = 1'b0;
      pm_held_cr   = 1'b0;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // one input transfer; expectations come from the typed units when given,
  // else from the model, which runs either way to keep its state
  task automatic send_unit(input in_item_t it, input logic [1:0] n_typed,
                           input unit_t t0, input unit_t t1);
    result_t r;
    while (sender_gaps && $urandom_range(99) < GAP_PERCENT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {it.second_byte, it.first_byte};
    s_axis_tlast  <= it.end_of_stream;
    do @(posedge clk); while (!s_axis_tready);
    // transfer taken at this edge
    units_sent++;
    if (it.end_of_stream) begin
      streams_sent++;
    end
    convert_unit(it);
    if (n_typed != 2'd0) begin
      unit_results.delete();
      unit_results.push_back(t0);
      if (n_typed == 2'd2) begin
        unit_results.push_back(t1);
      end
    end
    for (int i = 0; i < unit_results.size(); i++) begin
      r.u    = unit_results[i];
      r.last = (i == unit_results.size() - 1);
      pending_results.push_back(r);
    end
  endtask

  // stop sending and let every expected result drain, then let a held unit settle
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // raises the write channel and holds it until the transfer; does not lower it
  task automatic put_reg(input logic [1:0] idx, input logic [1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk); while (!cfg_ready_o);
    reg_writes++;
    case (idx)
      REG_SRC_NEWLINE: cfg_shadow.src_newline = data;
      REG_DST_NEWLINE: cfg_shadow.dst_newline = data;
      REG_SWAP_BYTES:  cfg_shadow.swap_bytes  = data[0];
      default: ;
    endcase
  endtask

  // all three registers back to back; the unused upper bit of swap is random
  task automatic write_styles(input cfg_t c);
    put_reg(REG_SRC_NEWLINE, c.src_newline);
    put_reg(REG_DST_NEWLINE, c.dst_newline);
    put_reg(REG_SWAP_BYTES, {1'($urandom_range(1)), c.swap_bytes});
    cfg_valid_i <= 1'b0;
    @(posedge clk);
  endtask

  function automatic cfg_t rand_styles();
    cfg_t c;
    c.src_newline = ($urandom_range(9) == 0) ? 2'd3 : 2'($urandom_range(2));
    c.dst_newline = ($urandom_range(9) == 0) ? 2'd3 : 2'($urandom_range(2));
    c.swap_bytes  = 1'($urandom_range(1));
    return c;
  endfunction

  // newlines in the stream's own byte order for half the units, some in the wrong order
  function automatic in_item_t rand_text_unit(input logic big_end, input logic eos);
    in_item_t it;
    int       pick;
    logic [15:0] code;
    pick = $urandom_range(99);
    if (pick < 30) begin
      code = CODE_CR;
    end else if (pick < 50) begin
      code = CODE_LF;
    end else if (pick < 58) begin
      code = $urandom_range(1) ? {CODE_CR[7:0], CODE_CR[15:8]} : {CODE_LF[7:0], CODE_LF[15:8]};
    end else begin
      code = 16'($urandom);
    end
    it.first_byte    = big_end ? code[15:8] : code[7:0];
    it.second_byte   = big_end ? code[7:0] : code[15:8];
    it.end_of_stream = eos;
    return it;
  endfunction

  function automatic in_item_t rand_mark(input logic eos);
    in_item_t it;
    int       pick;
    pick = $urandom_range(99);
    if (pick < 45) begin
      it.first_byte  = BOM_FIRST;
      it.second_byte = BOM_SECOND;
    end else if (pick < 85) begin
      it.first_byte  = BOM_SECOND;
      it.second_byte = BOM_FIRST;
    end else begin
      it.first_byte  = 8'($urandom);
      it.second_byte = 8'($urandom);
    end
    it.end_of_stream = eos;
    return it;
  endfunction

  function automatic dir_row_t unit_row(input logic [7:0] b0, input logic [7:0] b1,
                                        input logic eos, input logic [1:0] n_typed,
                                        input unit_t t0, input unit_t t1);
    dir_row_t row;
    row = '0;
    row.kind               = ROW_UNIT;
    row.item.first_byte    = b0;
    row.item.second_byte   = b1;
    row.item.end_of_stream = eos;
    row.n_typed            = n_typed;
    row.t0                 = t0;
    row.t1                 = t1;
    return row;
  endfunction

  function automatic dir_row_t cfg_row(input logic [1:0] src, input logic [1:0] dst,
                                       input logic swap);
    dir_row_t row;
    row = '0;
    row.kind               = ROW_CFG;
    row.styles.src_newline = src;
    row.styles.dst_newline = dst;
    row.styles.swap_bytes  = swap;
    return row;
  endfunction

  // ---------------------------------------------------------------------------
  // result side: random stalls and in-order checking
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    result_t want;
    if (rst_n) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result %h last %b", m_axis_tdata, m_axis_tlast));
        end else begin
          want = pending_results.pop_front();
          results_checked++;
          if (m_axis_tdata[7:0] !== want.u.first) begin
            report_mismatch($sformatf("out_first_byte %h, want %h",
                                      m_axis_tdata[7:0], want.u.first));
          end
          if (m_axis_tdata[15:8] !== want.u.second) begin
            report_mismatch($sformatf("out_second_byte %h, want %h",
                                      m_axis_tdata[15:8], want.u.second));
          end
          if (m_axis_tlast !== want.last) begin
            report_mismatch($sformatf("last_of_run %b, want %b", m_axis_tlast, want.last));
          end
        end
      end
      m_axis_tready <= !(sink_gaps && $urandom_range(99) < GAP_PERCENT);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout with %0d results outstanding", pending_results.size());
      $display("[utf16_newline_converter] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    dir_row_t row;
    in_item_t it;
    int       rand_sent;
    int       len;
    logic     eos;
    logic     pressure_done;

    // directed table; typed rows carry results that can be read off directly
    // reset styles, big endian mark and plain copies
    dir_rows.push_back(unit_row(8'hFE, 8'hFF, 1'b0, 2'd1, {8'hFE, 8'hFF}, '0));
    dir_rows.push_back(unit_row(8'h00, 8'h0A, 1'b0, 2'd0, '0, '0));
    dir_rows.push_back(unit_row(8'hFF, 8'hFF, 1'b1, 2'd1, {8'hFF, 8'hFF}, '0));
    // unix to windows with swapping, little endian
    dir_rows.push_back(cfg_row(NL_UNIX, NL_WIN, 1'b1));
    dir_rows.push_back(unit_row(8'hFF, 8'hFE, 1'b0, 2'd1, {8'hFE, 8'hFF}, '0));
    dir_rows.push_back(unit_row(8'h0A, 8'h00, 1'b0, 2'd2, {8'h00, 8'h0D}, {8'h00, 8'h0A}));
    dir_rows.push_back(unit_row(8'h00, 8'h00, 1'b1, 2'd0, '0, '0));
    // windows to unix: held cr then lf, cr then cr, cr then text, cr at the end
    dir_rows.push_back(cfg_row(NL_WIN, NL_UNIX, 1'b0));
    dir_rows.push_back(unit_row(8'h00, 8'h00, 1'b0, 2'd0, '0, '0));
    dir_rows.push_back(unit_row(8'h0D, 8'h00, 1'b0, 2'd0, '0, '0));
    dir_rows.push_back(unit_row(8'h0A, 8'h00, 1'b0, 2'd0, '0, '0));
    dir_rows.push_back(unit_row(8'h0D, 8'h00, 1'b0, 2'd0, '0, '0));
    dir_rows.push_back(unit_row(8'h0D, 8'h00, 1'b0, 2'd0, '0, '0));
    dir_rows.push_back(unit_row(8'h41, 8'h00, 1'b0, 2'd0, '0, '0));
    dir_rows.push_back(unit_row(8'h0D, 8'h00, 1'b1, 2'd0, '0, '0));
    // big endian cr held across a register write
    dir_rows.push_back(unit_row(8'hFE, 8'hFF, 1'b0, 2'd0, '0, '0));
    dir_rows.push_back(unit_row(8'h00, 8'h0D, 1'b0, 2'd0, '0, '0));
    dir_rows.push_back(cfg_row(NL_WIN, NL_MAC, 1'b0));
    dir_rows.push_back(unit_row(8'h00, 8'h0A, 1'b0, 2'd0, '0, '0));
    // mac source to unix and to windows
    dir_rows.push_back(cfg_row(NL_MAC, NL_UNIX, 1'b0));
    dir_rows.push_back(unit_row(8'h00, 8'h0D, 1'b0, 2'd0, '0, '0));
    dir_rows.push_back(cfg_row(NL_MAC, NL_WIN, 1'b1));
    dir_rows.push_back(unit_row(8'h00, 8'h0D, 1'b0, 2'd0, '0, '0));
    // style code three copies
    dir_rows.push_back(cfg_row(2'd3, NL_WIN, 1'b0));
    dir_rows.push_back(unit_row(8'h00, 8'h0D, 1'b0, 2'd0, '0, '0));
    dir_rows.push_back(unit_row(8'h00, 8'h0A, 1'b1, 2'd0, '0, '0));
    // mark alone, then unix to mac little endian
    dir_rows.push_back(cfg_row(NL_UNIX, NL_MAC, 1'b0));
    dir_rows.push_back(unit_row(8'h12, 8'h34, 1'b1, 2'd1, {8'h12, 8'h34}, '0));
    dir_rows.push_back(unit_row(8'h0A, 8'h00, 1'b0, 2'd0, '0, '0));
    dir_rows.push_back(unit_row(8'h0A, 8'h00, 1'b0, 2'd0, '0, '0));
    dir_rows.push_back(unit_row(8'h0D, 8'h00, 1'b1, 2'd0, '0, '0));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.kind == ROW_CFG) begin
        wait_drained();
        write_styles(row.styles);
      end else begin
        send_unit(row.item, row.n_typed, row.t0, row.t1);
      end
    end
    wait_drained();

    // random streams: mark, then text rich in newlines, closed by tlast;
    // a few streams end early or carry a random mark
    rand_sent = 0;
    pressure_done = 1'b0;
    while (rand_sent < RANDOM_UNITS) begin
      // a long stretch where neither side idles
      sender_gaps = !(rand_sent >= 350 && rand_sent < 500);
      sink_gaps   = sender_gaps;
      if ($urandom_range(3) == 0) begin
        wait_drained();
        write_styles(rand_styles());
      end
      if (!pressure_done && rand_sent >= 250) begin
        wait_drained();
        pressure_done = 1'b1;
      end
      len = ($urandom_range(99) < 10) ? 0 : $urandom_range(16, 1);
      send_unit(rand_mark(len == 0), 2'd0, '0, '0);
      rand_sent++;
      for (int k = 0; k < len; k++) begin
        // registers rewritten mid-stream, possibly with a cr held
        if ($urandom_range(99) < 3) begin
          wait_drained();
          write_styles(rand_styles());
        end
        eos = (k == len - 1) || ($urandom_range(99) < 3);
        it = rand_text_unit(pm_big_endian, eos);
        send_unit(it, 2'd0, '0, '0);
        rand_sent++;
        if (eos) begin
          break;
        end
      end
    end

    sender_gaps = 1'b1;
    sink_gaps   = 1'b1;
    wait_drained();

    $display("sent %0d units in %0d streams over %0d register writes",
             units_sent, streams_sent, reg_writes);
    $display("checked %0d results, %0d mismatches", results_checked, err_count);
    if (err_count == 0) begin
      $display("[utf16_newline_converter] OK");
    end else begin
      $display("[utf16_newline_converter] ERROR");
    end
    $finish;
  end

endmodule
